// ===== hw/rtl/bmon_pkg.sv =====
// Package for the battery level monitor: widths, codes, item structs and
// the fixed voltage-to-charge breakpoint table. No dependencies.
`timescale 1ns / 1ps

package bmon_pkg;

  localparam int VOLT_W    = 16;
  localparam int PCT_W     = 7;
  localparam int LVL_W     = 2;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;

  localparam int AVERAGE_COUNT_DEF = 4;

  // Breakpoint table, highest voltage first
  localparam int CHARGE_POINTS = 7;
  localparam int SEGMENTS      = CHARGE_POINTS - 1;

  localparam logic [VOLT_W-1:0] SOC_MV [CHARGE_POINTS] = '{
    16'd25200, 16'd24000, 16'd22800, 16'd21000, 16'd20000, 16'd19000, 16'd18000
  };
  localparam logic [PCT_W-1:0] SOC_PCT [CHARGE_POINTS] = '{
    7'd100, 7'd85, 7'd70, 7'd50, 7'd30, 7'd12, 7'd0
  };
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // Segment numerator: percent span times voltage offset
  localparam int NUM_W  = PCT_W + VOLT_W;
  // Shift-subtract divider quotient
  localparam int QUO_W  = 16;
  localparam int QIDX_W = $clog2(QUO_W);

  localparam logic [CFG_W-1:0] LOCKOUT_RST  = 16'd18000;
  localparam logic [CFG_W-1:0] LOW_WARN_RST = 16'd19000;

  typedef enum logic [OP_W-1:0] {
    OP_RESTING = 2'd0,
    OP_LOADED  = 2'd1,
    OP_QUERY   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOCKOUT  = 1'b0,
    CFG_LOW_WARN = 1'b1
  } cfg_idx_t;

  localparam logic [LVL_W-1:0] LVL_OK   = 2'd0;
  localparam logic [LVL_W-1:0] LVL_LOW  = 2'd1;
  localparam logic [LVL_W-1:0] LVL_LOCK = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [VOLT_W-1:0] sample_a;
    logic [VOLT_W-1:0] sample_b;
    logic [VOLT_W-1:0] sample_c;
    logic [VOLT_W-1:0] sample_d;
  } in_item_t;

  typedef struct packed {
    logic [VOLT_W-1:0] voltage_mv;
    logic [LVL_W-1:0]  level;
    logic [PCT_W-1:0]  soc_percent;
    logic              up_allowed;
    logic              changed;
  } out_item_t;

  // What one interpolation lane reports
  typedef struct packed {
    logic              hit;
    logic [NUM_W-1:0]  num;
    logic [VOLT_W-1:0] den;
    logic [PCT_W-1:0]  base;
  } lane_res_t;

  typedef struct packed {
    logic              start;
    logic [QIDX_W-1:0] first_bit;
    logic [VOLT_W-1:0] divisor;
  } div_ctl_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_stat_t;

endpackage

// ===== hw/rtl/bmon_stream_if.sv =====
// Valid/ready stream interface used by both item channels.
// Payload type is supplied by the instantiating level.
`timescale 1ns / 1ps

interface bmon_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/battery_level_and_charge_monitor.sv =====
// Top level of the battery level and charge monitor.
// Depends on bmon_pkg, bmon_stream_if, bmon_seg_lane, bmon_merge, bmon_div.
`timescale 1ns / 1ps

// Usage
//   in_ch  : valid/ready stream of in_item_t (operation, four mV samples).
//            Operation 0 stores sample_a, 1 stores the floor average of
//            AVERAGE_COUNT samples (sample i taken from field i mod 4),
//            2 reports and clears the level-change flag, 3 only reports.
//   out_ch : valid/ready stream of out_item_t, exactly one per input item:
//            stored voltage, level, charge percent, up_allowed, changed.
//   cfg_*  : write port for lockout_mv (index 0) and low_warn_mv (index 1);
//            write only while no item is in flight.
// Timing
//   One item at a time. in_ch.ready is high only while the controller idles.
//   Resting items pass load and classify; loaded items add an average step
//   (registered sum, then a reciprocal multiply); query or unused code skip
//   classify. The 7-step percent divide is most of the work. Voltages at or
//   outside the table ends skip the divide. The next item can be taken in
//   the same cycle as the result appears.
// Reset
//   rst_n (sync, active low) restores thresholds 18000/19000 mV, zero stored
//   voltage, level ok and no pending change; no item is held.
// Stall
//   The result sits in an output register. The next item is accepted while
//   it waits; that item then holds at its final step until the slot frees.

module battery_level_and_charge_monitor
  import bmon_pkg::*;
#(
  parameter int AVERAGE_COUNT = AVERAGE_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  bmon_stream_if.sink          in_ch,
  bmon_stream_if.source        out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int SUM_W = VOLT_W + $clog2(AVERAGE_COUNT);
  localparam int DVD_W = (SUM_W > NUM_W) ? SUM_W : NUM_W;

  localparam logic [QIDX_W-1:0] SOC_FIRST = QIDX_W'(PCT_W - 1);

  // Average by reciprocal multiply: rounded-up 2^AVG_SHIFT / AVERAGE_COUNT.
  // Three spare shift bits keep the floor exact for any sum (count up to 8).
  localparam int AVG_SHIFT  = SUM_W + 3;
  localparam int AVG_PROD_W = SUM_W + AVG_SHIFT + 1;
  localparam logic [AVG_SHIFT:0] AVG_RECIP = (AVG_SHIFT+1)'(
    ((longint'(1) << AVG_SHIFT) + longint'(AVERAGE_COUNT) - 1) / longint'(AVERAGE_COUNT));

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LOAD  = 7'b0000010,
    ST_AVG   = 7'b0000100,
    ST_CLASS = 7'b0001000,
    ST_LANE  = 7'b0010000,
    ST_SOC   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  in_item_t          item_r, item_nxt;
  logic [CFG_W-1:0]  lockout_r, lockout_nxt;
  logic [CFG_W-1:0]  low_warn_r, low_warn_nxt;
  logic [VOLT_W-1:0] volt_r, volt_nxt;
  logic [LVL_W-1:0]  cur_r, cur_nxt;
  logic [LVL_W-1:0]  rep_r, rep_nxt;
  logic              pending_r, pending_nxt;
  logic              chg_r, chg_nxt;
  logic [PCT_W-1:0]  base_r, base_nxt;
  logic [PCT_W-1:0]  soc_r, soc_nxt;
  logic [SUM_W-1:0]  avg_sum_r, avg_sum_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [VOLT_W-1:0]     smp [4];
  logic [SUM_W-1:0]      sum;
  logic [AVG_PROD_W-1:0] avg_prod;
  logic [LVL_W-1:0]      lv;
  logic [PCT_W:0]        soc_sum;
  logic                  out_free;
  op_t                   op;

  lane_res_t         lanes [SEGMENTS];
  lane_res_t         sel;
  div_ctl_t          div_ctl;
  logic [DVD_W-1:0]  div_dvd;
  div_stat_t         div_stat;

  // Interpolation lanes, one per table segment
  for (genvar g = 0; g < SEGMENTS; g++) begin : g_lane
    bmon_seg_lane #(.SEG(g)) u_lane (
      .volt (volt_r),
      .res  (lanes[g])
    );
  end

  bmon_merge u_merge (
    .lanes (lanes),
    .sel   (sel)
  );

  bmon_div #(.DVD_W(DVD_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dvd),
    .stat     (div_stat)
  );

  assign op       = op_t'(item_r.operation);
  assign out_free = !out_valid_r || out_ch.ready;

  assign smp[0] = item_r.sample_a;
  assign smp[1] = item_r.sample_b;
  assign smp[2] = item_r.sample_c;
  assign smp[3] = item_r.sample_d;

  // Loaded-sample sum; wide enough for AVERAGE_COUNT full-scale readings
  always_comb begin
    sum = '0;
    for (int i = 0; i < AVERAGE_COUNT; i++) begin
      sum = sum + SUM_W'(smp[2'(i)]);
    end
  end

  // Floor average from the registered sum
  assign avg_prod = AVG_PROD_W'(avg_sum_r) * AVG_PROD_W'(AVG_RECIP);

  // Lockout test wins over low warning
  always_comb begin
    if (volt_r < lockout_r) begin
      lv = LVL_LOCK;
    end else if (volt_r < low_warn_r) begin
      lv = LVL_LOW;
    end else begin
      lv = LVL_OK;
    end
  end

  assign soc_sum = {1'b0, base_r} + {1'b0, div_stat.quotient[PCT_W-1:0]};

  // Divider request: percent divide from LANE
  always_comb begin
    div_ctl.start     = 1'b0;
    div_ctl.first_bit = SOC_FIRST;
    div_ctl.divisor   = sel.den;
    div_dvd           = DVD_W'(sel.num);
    if (state_r == ST_LANE) begin
      div_ctl.start = (volt_r < SOC_MV[0]) && (volt_r > SOC_MV[CHARGE_POINTS-1]);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    volt_nxt      = volt_r;
    cur_nxt       = cur_r;
    rep_nxt       = rep_r;
    pending_nxt   = pending_r;
    chg_nxt       = chg_r;
    base_nxt      = base_r;
    soc_nxt       = soc_r;
    avg_sum_nxt   = avg_sum_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    lockout_nxt   = lockout_r;
    low_warn_nxt  = low_warn_r;

    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LOCKOUT:  lockout_nxt  = cfg_data;
        CFG_LOW_WARN: low_warn_nxt = cfg_data;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          item_nxt  = in_ch.data;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        unique case (op)
          OP_RESTING: begin
            volt_nxt  = item_r.sample_a;
            state_nxt = ST_CLASS;
          end
          OP_LOADED: begin
            avg_sum_nxt = sum;
            state_nxt   = ST_AVG;
          end
          OP_QUERY: begin
            // pending flag or an unreported level both count as a change
            if (pending_r || (cur_r != rep_r)) begin
              rep_nxt     = cur_r;
              pending_nxt = 1'b0;
              chg_nxt     = 1'b1;
            end else begin
              chg_nxt = 1'b0;
            end
            state_nxt = ST_LANE;
          end
          OP_NONE: begin
            chg_nxt   = pending_r;
            state_nxt = ST_LANE;
          end
        endcase
      end
      ST_AVG: begin
        volt_nxt  = avg_prod[AVG_SHIFT +: VOLT_W];
        state_nxt = ST_CLASS;
      end
      ST_CLASS: begin
        if (lv != cur_r) begin
          cur_nxt     = lv;
          pending_nxt = 1'b1;
          chg_nxt     = 1'b1;
        end else begin
          chg_nxt = pending_r;
        end
        state_nxt = ST_LANE;
      end
      ST_LANE: begin
        base_nxt = sel.base;
        if (volt_r >= SOC_MV[0]) begin
          soc_nxt   = PCT_MAX;
          state_nxt = ST_OUT;
        end else if (volt_r <= SOC_MV[CHARGE_POINTS-1]) begin
          soc_nxt   = '0;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_SOC;
        end
      end
      ST_SOC: begin
        if (div_stat.done) begin
          soc_nxt   = (soc_sum > (PCT_W+1)'(PCT_MAX)) ? PCT_MAX : soc_sum[PCT_W-1:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_data_nxt.voltage_mv  = volt_r;
          out_data_nxt.level       = cur_r;
          out_data_nxt.soc_percent = soc_r;
          out_data_nxt.up_allowed  = (cur_r != LVL_LOCK);
          out_data_nxt.changed     = chg_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      lockout_r   <= LOCKOUT_RST;
      low_warn_r  <= LOW_WARN_RST;
      volt_r      <= '0;
      cur_r       <= LVL_OK;
      rep_r       <= LVL_OK;
      pending_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      lockout_r   <= lockout_nxt;
      low_warn_r  <= low_warn_nxt;
      volt_r      <= volt_nxt;
      cur_r       <= cur_nxt;
      rep_r       <= rep_nxt;
      pending_r   <= pending_nxt;
    end
    item_r     <= item_nxt;
    chg_r      <= chg_nxt;
    base_r     <= base_nxt;
    soc_r      <= soc_nxt;
    avg_sum_r  <= avg_sum_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Percent quotient can never exceed the segment's percent span
  a_soc_quo_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SOC && div_stat.done) |-> (div_stat.quotient[QUO_W-1:PCT_W] == '0))
    else $error("percent quotient out of range");

  // A query leaves nothing pending and the level reported
  a_query_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD && op == OP_QUERY) |=> (!pending_r && rep_r == cur_r))
    else $error("query did not clear change state");

  // Divider never raises done directly after a start
  a_div_no_early_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |=> !div_stat.done)
    else $error("divider finished right after start");

  // Reported charge stays within 0..100
  a_soc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.soc_percent <= PCT_MAX))
    else $error("charge percent above 100");

endmodule

// ===== hw/rtl/bmon_seg_lane.sv =====
// One interpolation lane: tests a voltage against one table segment and
// forms the segment numerator and span. Uses bmon_pkg.
`timescale 1ns / 1ps

module bmon_seg_lane
  import bmon_pkg::*;
#(
  parameter int SEG = 0
) (
  input  logic [VOLT_W-1:0] volt,
  output lane_res_t         res
);

  localparam logic [VOLT_W-1:0] HI = SOC_MV[SEG];
  localparam logic [VOLT_W-1:0] LO = SOC_MV[SEG+1];
  localparam logic [PCT_W-1:0]  HP = SOC_PCT[SEG];
  localparam logic [PCT_W-1:0]  LP = SOC_PCT[SEG+1];
  localparam logic [PCT_W-1:0]  DP = (HP >= LP) ? PCT_W'(HP - LP) : '0;

  logic [VOLT_W-1:0] diff;

  assign diff     = volt - LO;
  assign res.hit  = (volt <= HI) && (volt > LO);
  assign res.num  = NUM_W'(DP) * NUM_W'(diff);
  assign res.den  = HI - LO;
  assign res.base = LP;

endmodule

// ===== hw/rtl/bmon_merge.sv =====
// Merging stage: picks the report of the lane whose segment holds the
// voltage. Segments are disjoint, so at most one lane hits. Uses bmon_pkg.
`timescale 1ns / 1ps

module bmon_merge
  import bmon_pkg::*;
(
  input  lane_res_t lanes [SEGMENTS],
  output lane_res_t sel
);

  always_comb begin
    sel = '0;
    for (int i = 0; i < SEGMENTS; i++) begin
      if (lanes[i].hit) begin
        sel = lane_res_t'(sel | lanes[i]);
      end
    end
  end

endmodule

// ===== hw/rtl/bmon_div.sv =====
// Iterative shift-subtract divider, one quotient bit per cycle starting at
// a given bit. Caller guarantees the quotient fits. Uses bmon_pkg.
`timescale 1ns / 1ps

module bmon_div
  import bmon_pkg::*;
#(
  parameter int DVD_W = NUM_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctl_t         ctl,
  input  logic [DVD_W-1:0] dividend,
  output div_stat_t        stat
);

  localparam int TRIAL_W = VOLT_W + QUO_W;

  logic [DVD_W-1:0]   rem_r, rem_nxt;
  logic [QUO_W-1:0]   q_r, q_nxt;
  logic [QIDX_W-1:0]  k_r, k_nxt;
  logic [VOLT_W-1:0]  dsr_r, dsr_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [TRIAL_W-1:0] trial;
  logic [TRIAL_W-1:0] rem_ext;

  always_comb begin
    trial    = TRIAL_W'(dsr_r) << k_r;
    rem_ext  = TRIAL_W'(rem_r);
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    k_nxt    = k_r;
    dsr_nxt  = dsr_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      rem_nxt  = dividend;
      q_nxt    = '0;
      k_nxt    = ctl.first_bit;
      dsr_nxt  = ctl.divisor;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_ext >= trial) begin
        rem_nxt   = DVD_W'(rem_ext - trial);
        q_nxt[k_r] = 1'b1;
      end
      if (k_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        k_nxt = k_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    k_r   <= k_nxt;
    dsr_r <= dsr_nxt;
  end

  assign stat.done     = done_r;
  assign stat.quotient = q_r;

endmodule
